// ===== rtl/ppdc_pkg.sv =====
// ----------------------------------------------------------------------------
// ppdc_pkg
// Types and constants shared by the point projection and depth color block.
// ----------------------------------------------------------------------------
package ppdc_pkg;

  localparam int ADDR_W  = 6;
  localparam int DATA_W  = 64;
  localparam int CAM_W   = 35;
  localparam int NUM_W   = 54;
  localparam int DEN_W   = 38;
  localparam int SQ_W    = 64;
  localparam int ROOT_W  = 32;
  localparam int DIST_W  = 32;
  localparam int PIX_W   = 16;
  localparam int COL_W   = 8;

  localparam logic [2:0] REG_TRANSFORM_X = 3'd0;
  localparam logic [2:0] REG_TRANSFORM_Y = 3'd1;
  localparam logic [2:0] REG_TRANSFORM_Z = 3'd2;
  localparam logic [2:0] REG_INTRINSIC_U = 3'd3;
  localparam logic [2:0] REG_INTRINSIC_V = 3'd4;
  localparam logic [2:0] REG_MAX_DIST    = 3'd5;
  localparam logic [2:0] REG_IMG_WIDTH   = 3'd6;
  localparam logic [2:0] REG_IMG_HEIGHT  = 3'd7;

  localparam logic [DIST_W-1:0] DIST_RESET   = 32'd3276800;
  localparam logic [PIX_W-1:0]  WIDTH_RESET  = 16'd640;
  localparam logic [PIX_W-1:0]  HEIGHT_RESET = 16'd480;

  localparam logic [1:0] BAND_RISE_G = 2'd0;
  localparam logic [1:0] BAND_FALL_B = 2'd1;
  localparam logic [1:0] BAND_RISE_R = 2'd2;
  localparam logic [1:0] BAND_FALL_G = 2'd3;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_u;
    logic [PIX_W-1:0] pixel_v;
    logic [COL_W-1:0] colour_red;
    logic [COL_W-1:0] colour_green;
    logic [COL_W-1:0] colour_blue;
  } result_t;

  typedef struct packed {
    logic [63:0]       row_x;
    logic [63:0]       row_y;
    logic [63:0]       row_z;
    logic [47:0]       intr_u;
    logic [31:0]       intr_v;
    logic [DIST_W-1:0] max_dist;
    logic [PIX_W-1:0]  width;
    logic [PIX_W-1:0]  height;
  } cfg_t;

  typedef struct packed {
    logic signed [CAM_W-1:0] xc;
    logic signed [CAM_W-1:0] yc;
    logic signed [CAM_W-1:0] zc;
  } cam_t;

  typedef struct packed {
    logic [NUM_W-1:0] num_u;
    logic [NUM_W-1:0] num_v;
    logic [DEN_W-1:0] den;
    logic [SQ_W-1:0]  range_sq;
    logic             clamp;
  } proj_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pix_u;
    logic [PIX_W-1:0]  pix_v;
    logic [ROOT_W-1:0] root;
    logic              clamp;
  } core_t;

  function automatic logic [DIST_W-1:0] eff_dist(logic [DIST_W-1:0] d);
    return (d == '0) ? DIST_W'(1) : d;
  endfunction

endpackage

// ===== rtl/ppdc_xform.sv =====
// ----------------------------------------------------------------------------
// ppdc_xform
// Rigid transform of a point into the camera frame, two register stages.
// ----------------------------------------------------------------------------
module ppdc_xform (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  ppdc_pkg::point_t in_data,
  input  ppdc_pkg::cfg_t  cfg,
  output logic            out_valid,
  output ppdc_pkg::cam_t  out_data
);
  import ppdc_pkg::*;

  logic [63:0]        rows  [3];
  logic signed [31:0] coord [3];
  logic signed [47:0] prod  [3][3];
  logic signed [15:0] trans [3];
  logic signed [48:0] acc   [3];
  logic               v1;

  always_comb begin
    rows[0]  = cfg.row_x;
    rows[1]  = cfg.row_y;
    rows[2]  = cfg.row_z;
    coord[0] = in_data.point_x;
    coord[1] = in_data.point_y;
    coord[2] = in_data.point_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod[r][k] <= coord[k] * $signed(rows[r][16*k +: 16]);
        end
        trans[r] <= rows[r][63:48];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 49'(prod[r][0]) + 49'(prod[r][1]) + 49'(prod[r][2])
             + (49'(trans[r]) <<< 22) + 49'sd8192;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.xc <= acc[0][48:14];
      out_data.yc <= acc[1][48:14];
      out_data.zc <= acc[2][48:14];
    end
  end

endmodule

// ===== rtl/ppdc_prep.sv =====
// ----------------------------------------------------------------------------
// ppdc_prep
// Projection numerators, squared range and visibility checks, three stages.
// ----------------------------------------------------------------------------
module ppdc_prep (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  ppdc_pkg::cam_t in_data,
  input  ppdc_pkg::cfg_t cfg,
  output logic           out_valid,
  output ppdc_pkg::proj_t out_data
);
  import ppdc_pkg::*;

  logic [DIST_W-1:0]       m;
  logic [SQ_W-1:0]         mm;
  logic [CAM_W-1:0]        mag [3];
  logic signed [CAM_W-1:0] cin [3];

  logic                    v1, v2;
  logic signed [51:0]      pu0, pu1, pu2, pv0, pv1;
  logic [SQ_W-1:0]         sq [3];
  logic [2:0]              big1;
  logic signed [CAM_W-1:0] zc1;

  logic signed [NUM_W-1:0] nu2, nv2;
  logic [DEN_W-1:0]        den2;
  logic [SQ_W+1:0]         sum2;
  logic                    big2;
  logic                    ok_u, ok_v;

  assign m = eff_dist(cfg.max_dist);

  always_comb begin
    cin[0] = in_data.xc;
    cin[1] = in_data.yc;
    cin[2] = in_data.zc;
    for (int c = 0; c < 3; c++) begin
      mag[c] = cin[c][CAM_W-1] ? CAM_W'(-cin[c]) : CAM_W'(cin[c]);
    end
  end

  always_ff @(posedge clk) begin
    mm <= m * m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid && !in_data.zc[CAM_W-1] && (in_data.zc != '0);
      v2        <= v1;
      out_valid <= v2 && ok_u && ok_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pu0 <= $signed({1'b0, cfg.intr_u[15:0]})  * in_data.xc;
      pu1 <= $signed({1'b0, cfg.intr_u[31:16]}) * in_data.yc;
      pu2 <= $signed({1'b0, cfg.intr_u[47:32]}) * in_data.zc;
      pv0 <= $signed({1'b0, cfg.intr_v[15:0]})  * in_data.yc;
      pv1 <= $signed({1'b0, cfg.intr_v[31:16]}) * in_data.zc;
      for (int c = 0; c < 3; c++) begin
        sq[c]   <= mag[c][31:0] * mag[c][31:0];
        big1[c] <= |mag[c][CAM_W-1:32];
      end
      zc1 <= in_data.zc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nu2  <= NUM_W'(pu0) + NUM_W'(pu1) + NUM_W'(pu2) + (NUM_W'(zc1) <<< 3);
      nv2  <= NUM_W'(pv0) + NUM_W'(pv1) + (NUM_W'(zc1) <<< 3);
      den2 <= {zc1[DEN_W-5:0], 4'b0000};
      sum2 <= (SQ_W+2)'(sq[0]) + (SQ_W+2)'(sq[1]) + (SQ_W+2)'(sq[2]);
      big2 <= |big1;
    end
  end

  always_comb begin
    ok_u = !nu2[NUM_W-1] && ({1'b0, nu2} < {1'b0, den2, 16'b0});
    ok_v = !nv2[NUM_W-1] && ({1'b0, nv2} < {1'b0, den2, 16'b0});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.num_u    <= nu2;
      out_data.num_v    <= nv2;
      out_data.den      <= den2;
      out_data.range_sq <= sum2[SQ_W-1:0];
      out_data.clamp    <= big2 || (sum2 >= {2'b00, mm});
    end
  end

endmodule

// ===== rtl/ppdc_core.sv =====
// ----------------------------------------------------------------------------
// ppdc_core
// Pipelined square root of the range and pixel division, one bit per stage.
// ----------------------------------------------------------------------------
module ppdc_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  ppdc_pkg::proj_t in_data,
  output logic            out_valid,
  output ppdc_pkg::core_t out_data
);
  import ppdc_pkg::*;

  typedef struct packed {
    logic [SQ_W-1:0]  rad;
    logic [SQ_W-1:0]  root;
    logic [NUM_W-1:0] rem_u;
    logic [NUM_W-1:0] rem_v;
    logic [DEN_W-1:0] den;
    logic [PIX_W-1:0] q_u;
    logic [PIX_W-1:0] q_v;
    logic             clamp;
  } step_t;

  step_t cur [ROOT_W];
  step_t nxt [ROOT_W];
  step_t sr  [ROOT_W];
  logic  vld [ROOT_W];

  always_comb begin
    logic [SQ_W:0]    trial;
    logic [SQ_W-1:0]  bitv;
    logic [NUM_W-1:0] dsh;
    int               idx;
    cur[0].rad   = in_data.range_sq;
    cur[0].root  = '0;
    cur[0].rem_u = in_data.num_u;
    cur[0].rem_v = in_data.num_v;
    cur[0].den   = in_data.den;
    cur[0].q_u   = '0;
    cur[0].q_v   = '0;
    cur[0].clamp = in_data.clamp;
    for (int k = 1; k < ROOT_W; k++) begin
      cur[k] = sr[k-1];
    end
    for (int k = 0; k < ROOT_W; k++) begin
      nxt[k] = cur[k];
      bitv   = SQ_W'(1) << (2 * (ROOT_W - 1 - k));
      trial  = {1'b0, cur[k].root} + {1'b0, bitv};
      if ({1'b0, cur[k].rad} >= trial) begin
        nxt[k].rad  = cur[k].rad - trial[SQ_W-1:0];
        nxt[k].root = (cur[k].root >> 1) + bitv;
      end else begin
        nxt[k].root = cur[k].root >> 1;
      end
      idx = PIX_W - 1 - k;
      dsh = '0;
      if (k < PIX_W) begin
        dsh = NUM_W'(cur[k].den) << idx;
        if (cur[k].rem_u >= dsh) begin
          nxt[k].rem_u    = cur[k].rem_u - dsh;
          nxt[k].q_u[idx] = 1'b1;
        end
        if (cur[k].rem_v >= dsh) begin
          nxt[k].rem_v    = cur[k].rem_v - dsh;
          nxt[k].q_v[idx] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ROOT_W; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < ROOT_W; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_W; k++) sr[k] <= nxt[k];
    end
  end

  assign out_valid      = vld[ROOT_W-1];
  assign out_data.pix_u = sr[ROOT_W-1].q_u;
  assign out_data.pix_v = sr[ROOT_W-1].q_v;
  assign out_data.root  = sr[ROOT_W-1].root[ROOT_W-1:0];
  assign out_data.clamp = sr[ROOT_W-1].clamp;

endmodule

// ===== rtl/ppdc_colour.sv =====
// ----------------------------------------------------------------------------
// ppdc_colour
// Bounds check and jet color from the range, with a pipelined 8-bit divide.
// ----------------------------------------------------------------------------
module ppdc_colour (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  ppdc_pkg::core_t   in_data,
  input  ppdc_pkg::cfg_t    cfg,
  output logic              out_valid,
  output ppdc_pkg::result_t out_data
);
  import ppdc_pkg::*;

  localparam int T_W = DIST_W + 2;
  localparam int X_W = DIST_W + 10;

  typedef struct packed {
    logic [X_W-1:0]   rem;
    logic [COL_W-1:0] q;
    logic [1:0]       band;
    logic [PIX_W-1:0] pix_u;
    logic [PIX_W-1:0] pix_v;
  } dstep_t;

  logic [DIST_W-1:0] m;
  logic [T_W-1:0]    m2, m3, m4;

  logic              v1, v2, v3, v4;
  logic [T_W-1:0]    t1, t2;
  logic [1:0]        band2, band3, band4;
  logic [DIST_W-1:0] num3;
  logic [X_W-1:0]    x4;
  logic [PIX_W-1:0]  u1, u2, u3, u4, w1, w2, w3, w4;
  logic [T_W-1:0]    diff;

  dstep_t cur [COL_W];
  dstep_t nxt [COL_W];
  dstep_t sr  [COL_W];
  logic   vld [COL_W];

  assign m = eff_dist(cfg.max_dist);

  always_ff @(posedge clk) begin
    m2 <= {1'b0, m, 1'b0};
    m3 <= T_W'(m) + {1'b0, m, 1'b0};
    m4 <= {m, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid && (in_data.pix_u < cfg.width) && (in_data.pix_v < cfg.height);
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_comb begin
    case (band2)
      BAND_RISE_G: diff = t2;
      BAND_FALL_B: diff = m2 - t2;
      BAND_RISE_R: diff = t2 - m2;
      default:     diff = m4 - t2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= in_data.clamp ? {m, 2'b00} : {in_data.root, 2'b00};
      u1 <= in_data.pix_u;
      w1 <= in_data.pix_v;
      t2 <= t1;
      if (t1 < T_W'(m)) begin
        band2 <= BAND_RISE_G;
      end else if (t1 < m2) begin
        band2 <= BAND_FALL_B;
      end else if (t1 < m3) begin
        band2 <= BAND_RISE_R;
      end else begin
        band2 <= BAND_FALL_G;
      end
      u2    <= u1;
      w2    <= w1;
      band3 <= band2;
      u3    <= u2;
      w3    <= w2;
      num3  <= diff[DIST_W-1:0];
      x4    <= (X_W'(num3) << 9) - (X_W'(num3) << 1) + X_W'(m);
      band4 <= band3;
      u4    <= u3;
      w4    <= w3;
    end
  end

  always_comb begin
    logic [X_W-1:0] dsh;
    cur[0].rem   = x4;
    cur[0].q     = '0;
    cur[0].band  = band4;
    cur[0].pix_u = u4;
    cur[0].pix_v = w4;
    for (int k = 1; k < COL_W; k++) begin
      cur[k] = sr[k-1];
    end
    for (int k = 0; k < COL_W; k++) begin
      nxt[k] = cur[k];
      dsh    = X_W'({m, 1'b0}) << (COL_W - 1 - k);
      if (cur[k].rem >= dsh) begin
        nxt[k].rem              = cur[k].rem - dsh;
        nxt[k].q[COL_W - 1 - k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < COL_W; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= v4;
      for (int k = 1; k < COL_W; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < COL_W; k++) sr[k] <= nxt[k];
    end
  end

  always_comb begin
    out_data.pixel_u = sr[COL_W-1].pix_u;
    out_data.pixel_v = sr[COL_W-1].pix_v;
    case (sr[COL_W-1].band)
      BAND_RISE_G: begin
        out_data.colour_red   = '0;
        out_data.colour_green = sr[COL_W-1].q;
        out_data.colour_blue  = '1;
      end
      BAND_FALL_B: begin
        out_data.colour_red   = '0;
        out_data.colour_green = '1;
        out_data.colour_blue  = sr[COL_W-1].q;
      end
      BAND_RISE_R: begin
        out_data.colour_red   = sr[COL_W-1].q;
        out_data.colour_green = '1;
        out_data.colour_blue  = '0;
      end
      default: begin
        out_data.colour_red   = '1;
        out_data.colour_green = sr[COL_W-1].q;
        out_data.colour_blue  = '0;
      end
    endcase
  end

  assign out_valid = vld[COL_W-1];

endmodule

// ===== rtl/point_projection_depth_colour.sv =====
// ----------------------------------------------------------------------------
// point_projection_depth_colour
// Lidar point to camera pixel projection with a jet color from range.
// ----------------------------------------------------------------------------
// One point is taken every clock cycle while point_stall is low. A visible
// point passes two stages of transform, three of projection setup, 32 of
// the bit-per-stage square root (the pixel division runs in its first 16),
// twelve of color and the output register. Points behind the camera or
// outside the image give no result. A two-entry output buffer takes one
// more result while a result is held by the downstream stall.
module point_projection_depth_colour (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ppdc_pkg::ADDR_W-1:0]    paddr,
  input  logic [ppdc_pkg::DATA_W-1:0]    pwdata,
  output logic [ppdc_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  input  logic                           point_valid,
  output logic                           point_stall,
  input  ppdc_pkg::point_t               point_data,
  output logic                           result_valid,
  input  logic                           result_stall,
  output ppdc_pkg::result_t              result_data
);
  import ppdc_pkg::*;

  cfg_t    cfg;
  logic    en;
  logic    cam_v, proj_v, core_v, col_v;
  cam_t    cam_d;
  proj_t   proj_d;
  core_t   core_d;
  result_t col_d;
  logic    skid_v;
  result_t skid_d;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_x    <= '0;
      cfg.row_y    <= '0;
      cfg.row_z    <= '0;
      cfg.intr_u   <= '0;
      cfg.intr_v   <= '0;
      cfg.max_dist <= DIST_RESET;
      cfg.width    <= WIDTH_RESET;
      cfg.height   <= HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[5:3])
        REG_TRANSFORM_X: cfg.row_x    <= pwdata;
        REG_TRANSFORM_Y: cfg.row_y    <= pwdata;
        REG_TRANSFORM_Z: cfg.row_z    <= pwdata;
        REG_INTRINSIC_U: cfg.intr_u   <= pwdata[47:0];
        REG_INTRINSIC_V: cfg.intr_v   <= pwdata[31:0];
        REG_MAX_DIST:    cfg.max_dist <= pwdata[DIST_W-1:0];
        REG_IMG_WIDTH:   cfg.width    <= pwdata[PIX_W-1:0];
        REG_IMG_HEIGHT:  cfg.height   <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_TRANSFORM_X: prdata = cfg.row_x;
      REG_TRANSFORM_Y: prdata = cfg.row_y;
      REG_TRANSFORM_Z: prdata = cfg.row_z;
      REG_INTRINSIC_U: prdata = DATA_W'(cfg.intr_u);
      REG_INTRINSIC_V: prdata = DATA_W'(cfg.intr_v);
      REG_MAX_DIST:    prdata = DATA_W'(cfg.max_dist);
      REG_IMG_WIDTH:   prdata = DATA_W'(cfg.width);
      REG_IMG_HEIGHT:  prdata = DATA_W'(cfg.height);
      default:         prdata = '0;
    endcase
  end

  assign en          = !skid_v;
  assign point_stall = skid_v;

  ppdc_xform u_xform (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(point_valid), .in_data(point_data), .cfg(cfg),
    .out_valid(cam_v), .out_data(cam_d)
  );

  ppdc_prep u_prep (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(cam_v), .in_data(cam_d), .cfg(cfg),
    .out_valid(proj_v), .out_data(proj_d)
  );

  ppdc_core u_core (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(proj_v), .in_data(proj_d),
    .out_valid(core_v), .out_data(core_d)
  );

  ppdc_colour u_colour (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(core_v), .in_data(core_d), .cfg(cfg),
    .out_valid(col_v), .out_data(col_d)
  );

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_v       <= 1'b0;
    end else if (skid_v) begin
      if (!result_valid || !result_stall) begin
        result_valid <= 1'b1;
        skid_v       <= 1'b0;
      end
    end else if (col_v) begin
      if (!result_valid || !result_stall) begin
        result_valid <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (!result_valid || !result_stall) result_data <= skid_d;
    end else if (col_v) begin
      if (!result_valid || !result_stall) result_data <= col_d;
      else skid_d <= col_d;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> result_valid)
    else $error("skid entry held with output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(result_valid && result_stall && col_v))
    else $error("skid filled without a stalled output transfer");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    ($fell(skid_v) && !$past(rst)) |-> result_valid)
    else $error("skid entry lost on drain");

endmodule

// ===== test/point_projection_depth_colour_tb.sv =====
// ----------------------------------------------------------------------------
// point_projection_depth_colour_tb
// Streams lidar points through the projection block under several register
// settings and handshake idling patterns. Each accepted point is projected by
// an in-bench model, and every visible pixel and its jet color are compared
// field by field with the block's result transfers in order.
// ----------------------------------------------------------------------------
module point_projection_depth_colour_tb;
  import ppdc_pkg::*;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                point_valid;
  logic                point_stall;
  point_t              point_data;
  logic                result_valid;
  logic                result_stall;
  result_t             result_data;

  point_t              pending_points[$];
  result_t             expected_pixels[$];
  logic [63:0]         regs_model[8];
  int                  idle_pct;
  int                  stall_pct;
  int                  mismatches;
  int                  quiet_cycles;
  logic                point_taken;

  point_projection_depth_colour u_top (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .point_valid(point_valid), .point_stall(point_stall), .point_data(point_data),
    .result_valid(result_valid), .result_stall(result_stall),
    .result_data(result_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint camera_axis(logic [63:0] row, point_t p);
    longint acc;
    acc = longint'($signed(p.point_x)) * longint'($signed(row[15:0]))
        + longint'($signed(p.point_y)) * longint'($signed(row[31:16]))
        + longint'($signed(p.point_z)) * longint'($signed(row[47:32]))
        + longint'($signed(row[63:48])) * (longint'(1) << 22);
    return (acc + 8192) >>> 14;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int i = 31; i >= 0; i--) begin
      cand = res | (64'd1 << i);
      if (cand * cand <= n) res = cand;
    end
    return res;
  endfunction

  function automatic logic [63:0] square_of(longint c, inout logic big);
    logic [63:0] a;
    a = (c < 0) ? 64'(-c) : 64'(c);
    if (a >= 64'h1_0000_0000) begin
      big = 1'b1;
      return '0;
    end
    return a * a;
  endfunction

  function automatic logic [63:0] add_clip(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [7:0] scale255(logic [63:0] num, logic [63:0] m);
    return 8'((num * 510 + m) / (2 * m));
  endfunction

  function automatic logic project_point(point_t p, output result_t res);
    longint xc, yc, zc, num_u, num_v, u, v;
    logic [63:0] m, sum, t;
    logic big;
    res = '0;
    big = 1'b0;
    xc = camera_axis(regs_model[REG_TRANSFORM_X], p);
    yc = camera_axis(regs_model[REG_TRANSFORM_Y], p);
    zc = camera_axis(regs_model[REG_TRANSFORM_Z], p);
    if (zc <= 0) return 1'b0;
    num_u = longint'(regs_model[REG_INTRINSIC_U][15:0]) * xc
          + longint'(regs_model[REG_INTRINSIC_U][31:16]) * yc
          + longint'(regs_model[REG_INTRINSIC_U][47:32]) * zc;
    num_v = longint'(regs_model[REG_INTRINSIC_V][15:0]) * yc
          + longint'(regs_model[REG_INTRINSIC_V][31:16]) * zc;
    u = floor_div(num_u + 8 * zc, 16 * zc);
    v = floor_div(num_v + 8 * zc, 16 * zc);
    if (u < 0 || u >= longint'(regs_model[REG_IMG_WIDTH]) ||
        v < 0 || v >= longint'(regs_model[REG_IMG_HEIGHT])) return 1'b0;
    m = (regs_model[REG_MAX_DIST] == 0) ? 64'd1 : regs_model[REG_MAX_DIST];
    sum = add_clip(add_clip(square_of(xc, big), square_of(yc, big)), square_of(zc, big));
    if (big || sum >= m * m) t = 4 * m;
    else t = 4 * root_floor(sum);
    if (t > 4 * m) t = 4 * m;
    res.pixel_u = 16'(u);
    res.pixel_v = 16'(v);
    if (t < m) begin
      res.colour_red = 8'd0; res.colour_green = scale255(t, m); res.colour_blue = 8'd255;
    end else if (t < 2 * m) begin
      res.colour_red = 8'd0; res.colour_green = 8'd255; res.colour_blue = scale255(2 * m - t, m);
    end else if (t < 3 * m) begin
      res.colour_red = scale255(t - 2 * m, m); res.colour_green = 8'd255; res.colour_blue = 8'd0;
    end else begin
      res.colour_red = 8'd255; res.colour_green = scale255(4 * m - t, m); res.colour_blue = 8'd0;
    end
    return 1'b1;
  endfunction

  function automatic point_t point_at(int x, int y, int z);
    point_t p;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    return p;
  endfunction

  // mostly points in front of the sensor, some raw noise
  function automatic point_t scene_point();
    int fwd;
    int lat;
    if ($urandom_range(99) < 15) return point_at($urandom, $urandom, $urandom);
    fwd = $urandom_range(32'h0040_0000, 32'h0100);
    lat = fwd - fwd / 4;
    return point_at(fwd, $urandom_range(2 * lat) - lat, $urandom_range(2 * lat) - lat);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 3'b000}); pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_INTRINSIC_U: regs_model[idx] = {16'd0, val[47:0]};
      REG_INTRINSIC_V, REG_MAX_DIST: regs_model[idx] = {32'd0, val[31:0]};
      REG_IMG_WIDTH, REG_IMG_HEIGHT: regs_model[idx] = {48'd0, val[15:0]};
      default: regs_model[idx] = val;
    endcase
  endtask

  task automatic scene_setup(logic [31:0] max_dist, logic [15:0] w, logic [15:0] h,
                             logic [15:0] shift);
    // camera x = -lidar y, camera y = -lidar z, depth = lidar x
    write_reg(REG_TRANSFORM_X, {shift, 16'd0, 16'hC000, 16'd0});
    write_reg(REG_TRANSFORM_Y, {16'd0, 16'hC000, 16'd0, 16'd0});
    write_reg(REG_TRANSFORM_Z, {16'd0, 16'd0, 16'd0, 16'h4000});
    write_reg(REG_INTRINSIC_U, {16'(w * 8), 16'd0, 16'd8000});
    write_reg(REG_INTRINSIC_V, {16'(h * 8), 16'd8000});
    write_reg(REG_MAX_DIST, max_dist);
    write_reg(REG_IMG_WIDTH, w);
    write_reg(REG_IMG_HEIGHT, h);
  endtask

  task automatic drain();
    wait (pending_points.size() == 0 && !point_valid);
    wait (expected_pixels.size() == 0);
    repeat (60) @(negedge clk);
  endtask

  task automatic push_scene(int n);
    repeat (n) pending_points.push_back(scene_point());
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (!point_valid || point_taken) begin
      if (pending_points.size() != 0 && $urandom_range(99) >= idle_pct) begin
        point_valid <= 1'b1;
        point_data <= pending_points.pop_front();
      end else begin
        point_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    result_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    result_t exp_px;
    point_taken <= point_valid && !point_stall && !rst;
    if (!rst && point_valid && !point_stall) begin
      if (project_point(point_data, exp_px)) expected_pixels.push_back(exp_px);
    end
    if (!rst && result_valid && !result_stall) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", result_data);
      end else begin
        exp_px = expected_pixels.pop_front();
        if (result_data.pixel_u !== exp_px.pixel_u ||
            result_data.pixel_v !== exp_px.pixel_v ||
            result_data.colour_red !== exp_px.colour_red ||
            result_data.colour_green !== exp_px.colour_green ||
            result_data.colour_blue !== exp_px.colour_blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected u=%0d v=%0d rgb=%0d,%0d,%0d got u=%0d v=%0d rgb=%0d,%0d,%0d",
                     exp_px.pixel_u, exp_px.pixel_v, exp_px.colour_red,
                     exp_px.colour_green, exp_px.colour_blue, result_data.pixel_u,
                     result_data.pixel_v, result_data.colour_red,
                     result_data.colour_green, result_data.colour_blue);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((point_valid && !point_stall) || (result_valid && !result_stall) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] ahead_x [8];
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    point_valid = 1'b0; point_data = '0; result_stall = 1'b0; point_taken = 1'b0;
    idle_pct = 0; stall_pct = 0; mismatches = 0; quiet_cycles = 0;
    for (int i = 0; i < 8; i++) regs_model[i] = '0;
    regs_model[REG_MAX_DIST] = 64'(DIST_RESET);
    regs_model[REG_IMG_WIDTH] = 64'(WIDTH_RESET);
    regs_model[REG_IMG_HEIGHT] = 64'(HEIGHT_RESET);
    ahead_x = '{32'h0000_8000, 32'h000C_8000, 32'h0019_0000, 32'h0025_8000,
                32'h0032_0000, 32'h003C_0000, 32'h0000_0001, 32'h7FFF_FFFF};
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // reset values drop everything: depth row is zero
    pending_points.push_back(point_at(32'h000A_0000, 0, 0));
    drain();

    scene_setup(32'd3276800, 16'd640, 16'd480, 16'd0);
    // straight ahead across the color bands
    foreach (ahead_x[i])
      pending_points.push_back(point_at(ahead_x[i], 0, 0));
    pending_points.push_back(point_at(0, 0, 0));
    pending_points.push_back(point_at(32'h8000_0000, 0, 0));
    pending_points.push_back(point_at(32'hFFFF_0000, 32'h0001_0000, 0));
    pending_points.push_back(point_at(32'h000A_0000, 32'h7FFF_FFFF, 0));
    pending_points.push_back(point_at(32'h000A_0000, 32'h8000_0000, 32'h8000_0000));
    pending_points.push_back(point_at(32'h000A_0000, 32'h000A_0000, 32'h0007_8000));
    pending_points.push_back(point_at(32'h000A_0000, 32'hFFF6_0000, 32'hFFF8_8000));
    pending_points.push_back(point_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_points.push_back(point_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pending_points.push_back(point_at(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    push_scene(300);
    drain();

    idle_pct = 49;
    push_scene(150);
    drain();
    push_scene(150);
    drain();

    idle_pct = 0; stall_pct = 49;
    scene_setup(32'd1, 16'd65535, 16'd65535, 16'h0180);
    push_scene(250);
    drain();

    idle_pct = 38; stall_pct = 38;
    scene_setup(32'hFFFF_FFFF, 16'd1, 16'd1, 16'hFE80);
    push_scene(100);
    drain();
    write_reg(REG_TRANSFORM_X, {$urandom, $urandom});
    write_reg(REG_TRANSFORM_Y, {$urandom, $urandom});
    write_reg(REG_TRANSFORM_Z, {$urandom, $urandom});
    write_reg(REG_INTRINSIC_U, {$urandom, $urandom});
    write_reg(REG_INTRINSIC_V, 64'(32'hFFFF_FFFF));
    write_reg(REG_IMG_WIDTH, 64'(16'hFFFF));
    write_reg(REG_IMG_HEIGHT, 64'(16'hFFFF));
    push_scene(150);
    drain();

    idle_pct = 20; stall_pct = 20;
    scene_setup(32'h000A_0000, 16'd100, 16'd80, 16'h0040);
    push_scene(300);
    drain();

    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
